// ===== design/cpd_pkg.sv =====
package cpd_pkg;

  // Register stages of each part of the pipeline.
  localparam int SC_LAT   = 27;
  localparam int PROD_LAT = 4;
  localparam int DIV_LAT  = 35;
  localparam int TOT_LAT  = SC_LAT + PROD_LAT + DIV_LAT;

  localparam int CORDIC_STEPS = 24;
  localparam int DIV_STEPS    = 33;

  localparam logic signed [63:0] TURN_SCALE  = 64'sd683565276;
  localparam logic [61:0]        HALF_PI_Q30 = 62'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef logic signed [33:0] cordic_t;

  localparam cordic_t ATAN_TAB [CORDIC_STEPS] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  typedef enum logic [2:0] {
    CFG_CART_MASS   = 3'd0,
    CFG_POLE_MASS   = 3'd1,
    CFG_GRAVITY     = 3'd2,
    CFG_POLE_LENGTH = 3'd3,
    CFG_DAMPING     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } mul_t;

  // Q16.16 product, rounded half up and saturated.
  function automatic mul_t mulq(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [47:0] r;
    mul_t res;
    p = 64'(a) * 64'(b);
    p = p + 64'sd32768;
    r = p[63:16];
    if (r > 48'sd2147483647) begin
      res.val = Q_MAX;
      res.ovf = 1'b1;
    end else if (r < -48'sd2147483648) begin
      res.val = Q_MIN;
      res.ovf = 1'b1;
    end else begin
      res.val = r[31:0];
      res.ovf = 1'b0;
    end
    return res;
  endfunction

  function automatic mul_t sat33(input logic signed [32:0] v);
    mul_t res;
    if (v > 33'sd2147483647) begin
      res.val = Q_MAX;
      res.ovf = 1'b1;
    end else if (v < -33'sd2147483648) begin
      res.val = Q_MIN;
      res.ovf = 1'b1;
    end else begin
      res.val = v[31:0];
      res.ovf = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== design/cpd_sincos.sv =====
module cpd_sincos (
  input  logic               clk_i,
  input  logic signed [31:0] theta_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic [31:0]        phase_q;
  logic signed [63:0] ph_prod;
  logic [61:0]        z_prod;

  cpd_pkg::cordic_t x_q [cpd_pkg::CORDIC_STEPS+1];
  cpd_pkg::cordic_t y_q [cpd_pkg::CORDIC_STEPS+1];
  cpd_pkg::cordic_t z_q [cpd_pkg::CORDIC_STEPS+1];
  logic [1:0]       quad_q [cpd_pkg::CORDIC_STEPS+1];

  logic signed [31:0] s0, c0;
  logic signed [31:0] sin_d, cos_d;

  // Phase in units of 2^-32 turn.
  assign ph_prod = 64'(theta_i) * cpd_pkg::TURN_SCALE + 64'sd32768;

  always_ff @(posedge clk_i) begin
    phase_q <= ph_prod[47:16];
  end

  assign z_prod = 62'(phase_q[29:0]) * cpd_pkg::HALF_PI_Q30 + 62'h20000000;

  always_ff @(posedge clk_i) begin
    x_q[0]    <= cpd_pkg::CORDIC_GAIN;
    y_q[0]    <= '0;
    z_q[0]    <= 34'(z_prod[60:30]);
    quad_q[0] <= phase_q[31:30];
  end

  for (genvar i = 0; i < cpd_pkg::CORDIC_STEPS; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (!z_q[i][33]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - cpd_pkg::ATAN_TAB[i];
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + cpd_pkg::ATAN_TAB[i];
      end
      quad_q[i+1] <= quad_q[i];
    end
  end

  function automatic logic signed [31:0] to_q16(input cpd_pkg::cordic_t v);
    cpd_pkg::cordic_t   t;
    logic signed [19:0] r;
    t = v + 34'sd8192;
    r = t[33:14];
    if (r > 20'sd65536) return 32'sd65536;
    if (r < -20'sd65536) return -32'sd65536;
    return 32'(r);
  endfunction

  assign s0 = to_q16(y_q[cpd_pkg::CORDIC_STEPS]);
  assign c0 = to_q16(x_q[cpd_pkg::CORDIC_STEPS]);

  always_comb begin
    case (quad_q[cpd_pkg::CORDIC_STEPS])
      2'd0: begin
        sin_d = s0;
        cos_d = c0;
      end
      2'd1: begin
        sin_d = c0;
        cos_d = -s0;
      end
      2'd2: begin
        sin_d = -s0;
        cos_d = -c0;
      end
      default: begin
        sin_d = -c0;
        cos_d = s0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sin_o <= sin_d;
    cos_o <= cos_d;
  end

endmodule

// ===== design/cpd_div.sv =====
module cpd_div (
  input  logic               clk_i,
  input  logic signed [34:0] num_i,
  input  logic signed [31:0] den_i,
  output logic signed [31:0] quo_o,
  output logic               flt_o
);

  localparam int N = cpd_pkg::DIV_STEPS;

  logic [33:0] mag;
  logic [49:0] dividend;

  logic [31:0] rem_q  [N+1];
  logic [32:0] bits_q [N+1];
  logic [32:0] quo_q  [N+1];
  logic [31:0] den_q  [N+1];
  logic        zero_q [N+1];
  logic        neg_q  [N+1];
  logic        nz_q   [N+1];
  logic        ovf_q  [N+1];

  logic signed [31:0] quo_d;
  logic               flt_d;

  assign mag      = num_i[34] ? 34'(-num_i) : 34'(num_i);
  assign dividend = {mag, 16'd0};

  // The top bits form the first partial remainder; a quotient beyond 33 bits
  // is caught here.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= 32'(dividend[49:33]);
    bits_q[0] <= dividend[32:0];
    quo_q[0]  <= '0;
    den_q[0]  <= {1'b0, den_i[30:0]};
    zero_q[0] <= den_i <= 32'sd0;
    neg_q[0]  <= num_i[34];
    nz_q[0]   <= num_i != 35'sd0;
    ovf_q[0]  <= 32'(dividend[49:33]) >= {1'b0, den_i[30:0]};
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [31:0] trial;
    assign trial = {rem_q[k][30:0], bits_q[k][32]};
    always_ff @(posedge clk_i) begin
      if (trial >= den_q[k]) begin
        rem_q[k+1] <= trial - den_q[k];
        quo_q[k+1] <= {quo_q[k][31:0], 1'b1};
      end else begin
        rem_q[k+1] <= trial;
        quo_q[k+1] <= {quo_q[k][31:0], 1'b0};
      end
      bits_q[k+1] <= {bits_q[k][31:0], 1'b0};
      den_q[k+1]  <= den_q[k];
      zero_q[k+1] <= zero_q[k];
      neg_q[k+1]  <= neg_q[k];
      nz_q[k+1]   <= nz_q[k];
      ovf_q[k+1]  <= ovf_q[k];
    end
  end

  always_comb begin
    flt_d = 1'b0;
    quo_d = '0;
    if (zero_q[N]) begin
      flt_d = 1'b1;
      if (!nz_q[N]) quo_d = '0;
      else if (neg_q[N]) quo_d = cpd_pkg::Q_MIN;
      else quo_d = cpd_pkg::Q_MAX;
    end else if (ovf_q[N]) begin
      flt_d = 1'b1;
      quo_d = neg_q[N] ? cpd_pkg::Q_MIN : cpd_pkg::Q_MAX;
    end else if (!neg_q[N]) begin
      if (quo_q[N][32:31] != 2'd0) begin
        flt_d = 1'b1;
        quo_d = cpd_pkg::Q_MAX;
      end else begin
        quo_d = quo_q[N][31:0];
      end
    end else begin
      if (quo_q[N] > 33'h080000000) begin
        flt_d = 1'b1;
        quo_d = cpd_pkg::Q_MIN;
      end else begin
        quo_d = -(quo_q[N][31:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_o <= quo_d;
    flt_o <= flt_d;
  end

endmodule

// ===== design/cart_pole_derivatives.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         start_i, busy_o           cart_velocity_i, pole_angle_i,
//                                                angular_rate_i, drive_force_i
// result    out        done_o (one-cycle strobe) position_rate_o, cart_accel_o,
//                                                angle_rate_o, angular_accel_o,
//                                                math_error_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// A request is taken every cycle; busy_o stays low. Each result passes through
// angle reduction and CORDIC, then the product stages, then the
// one-bit-per-stage dividers. Reset clears the valid bits and loads the
// register defaults. The receiver cannot stall, so nothing in the pipeline
// ever waits.
module cart_pole_derivatives (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] cart_velocity_i,
  input  logic signed [31:0] pole_angle_i,
  input  logic signed [31:0] angular_rate_i,
  input  logic signed [31:0] drive_force_i,
  output logic               done_o,
  output logic signed [31:0] position_rate_o,
  output logic signed [31:0] cart_accel_o,
  output logic signed [31:0] angle_rate_o,
  output logic signed [31:0] angular_accel_o,
  output logic               math_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int TL = cpd_pkg::TOT_LAT;
  localparam int SL = cpd_pkg::SC_LAT;
  localparam int DL = cpd_pkg::DIV_LAT;

  logic accept;
  logic cfg_we;

  logic [30:0] cart_mass_q, pole_mass_q, gravity_q, pole_length_q, damping_q;
  logic signed [31:0] cm, pm, gr, pl, dp;

  // Products that depend only on configuration.
  logic signed [31:0] mg_q, ml_q, mm_q, mgl_q, mll_q, mmll_q;
  logic               cf1_q, cf2_q, cfg_flt_q;
  cpd_pkg::mul_t      c_mg, c_ml, c_mm, c_mgl, c_mll, c_mmll;

  logic               vld_q   [TL];
  logic signed [31:0] vel_dly [TL];
  logic signed [31:0] rate_dly [TL];
  logic signed [31:0] force_dly [SL];
  logic               flt_dly [DL];

  logic signed [31:0] sin_w, cos_w, w_in, f_in;

  // Stage 1
  cpd_pkg::mul_t e_ss, e_w2, e_cs, e_a, e_cd, e_lf, e_dw, e_mlc;
  logic signed [31:0] ss1_q, w21_q, cs1_q, a1_q, cd1_q, lf1_q, dw1_q, mlc1_q;
  logic signed [31:0] s1_q, c1_q, w1_q, f1_q;
  logic               flt1_q;
  // Stage 2
  cpd_pkg::mul_t e_mss, e_ac, e_mllw2, e_cdw, e_dwmm, e_amm, e_mlcf, e_mmllw2;
  logic signed [31:0] mss2_q, ac2_q, mllw22_q, cdw2_q, dwmm2_q, amm2_q, mlcf2_q;
  logic signed [31:0] mmllw22_q, s2_q, cs2_q, lf2_q;
  logic               flt2_q;
  // Stage 3
  cpd_pkg::mul_t e_dd, e_t2, e_t4;
  logic signed [31:0] dd3_q, t23_q, t43_q, ac3_q, cdw3_q, lf3_q, dwmm3_q, amm3_q;
  logic signed [31:0] mlcf3_q;
  logic               flt3_q;
  // Stage 4
  cpd_pkg::mul_t      e_den1, e_den2;
  logic signed [34:0] n1_sum, n2_sum;
  logic signed [34:0] num1_q, num2_q;
  logic signed [31:0] den1_q, den2_q;
  logic               flt4_q;

  logic signed [31:0] q1, q2;
  logic               qf1, qf2;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_mass_q   <= 31'd65536000;
      pole_mass_q   <= 31'd6554;
      gravity_q     <= 31'd642908;
      pole_length_q <= 31'd32768;
      damping_q     <= 31'd0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        cpd_pkg::CFG_CART_MASS:   cart_mass_q   <= cfg_data_i[30:0];
        cpd_pkg::CFG_POLE_MASS:   pole_mass_q   <= cfg_data_i[30:0];
        cpd_pkg::CFG_GRAVITY:     gravity_q     <= cfg_data_i[30:0];
        cpd_pkg::CFG_POLE_LENGTH: pole_length_q <= cfg_data_i[30:0];
        cpd_pkg::CFG_DAMPING:     damping_q     <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign cm = {1'b0, cart_mass_q};
  assign pm = {1'b0, pole_mass_q};
  assign gr = {1'b0, gravity_q};
  assign pl = {1'b0, pole_length_q};
  assign dp = {1'b0, damping_q};

  // Configuration settles through these three stages long before the first
  // request after a write reaches the product stages.
  assign c_mg   = cpd_pkg::mulq(pm, gr);
  assign c_ml   = cpd_pkg::mulq(pm, pl);
  assign c_mm   = cpd_pkg::sat33(33'(cm) + 33'(pm));
  assign c_mgl  = cpd_pkg::mulq(mg_q, pl);
  assign c_mll  = cpd_pkg::mulq(ml_q, pl);
  assign c_mmll = cpd_pkg::mulq(mll_q, pm);

  always_ff @(posedge clk_i) begin
    mg_q      <= c_mg.val;
    ml_q      <= c_ml.val;
    mm_q      <= c_mm.val;
    cf1_q     <= c_mg.ovf | c_ml.ovf | c_mm.ovf;
    mgl_q     <= c_mgl.val;
    mll_q     <= c_mll.val;
    cf2_q     <= cf1_q | c_mgl.ovf | c_mll.ovf;
    mmll_q    <= c_mmll.val;
    cfg_flt_q <= cf2_q | c_mmll.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TL; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i < TL; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    vel_dly[0]   <= cart_velocity_i;
    rate_dly[0]  <= angular_rate_i;
    force_dly[0] <= drive_force_i;
    flt_dly[0]   <= flt4_q;
    for (int i = 1; i < TL; i++) begin
      vel_dly[i]  <= vel_dly[i-1];
      rate_dly[i] <= rate_dly[i-1];
    end
    for (int i = 1; i < SL; i++) force_dly[i] <= force_dly[i-1];
    for (int i = 1; i < DL; i++) flt_dly[i] <= flt_dly[i-1];
  end

  cpd_sincos u_sincos (
    .clk_i   (clk_i),
    .theta_i (pole_angle_i),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  assign w_in = rate_dly[SL-1];
  assign f_in = force_dly[SL-1];

  assign e_ss  = cpd_pkg::mulq(sin_w, sin_w);
  assign e_w2  = cpd_pkg::mulq(w_in, w_in);
  assign e_cs  = cpd_pkg::mulq(cos_w, sin_w);
  assign e_a   = cpd_pkg::mulq(mgl_q, sin_w);
  assign e_cd  = cpd_pkg::mulq(cos_w, dp);
  assign e_lf  = cpd_pkg::mulq(pl, f_in);
  assign e_dw  = cpd_pkg::mulq(dp, w_in);
  assign e_mlc = cpd_pkg::mulq(ml_q, cos_w);

  always_ff @(posedge clk_i) begin
    ss1_q  <= e_ss.val;
    w21_q  <= e_w2.val;
    cs1_q  <= e_cs.val;
    a1_q   <= e_a.val;
    cd1_q  <= e_cd.val;
    lf1_q  <= e_lf.val;
    dw1_q  <= e_dw.val;
    mlc1_q <= e_mlc.val;
    s1_q   <= sin_w;
    c1_q   <= cos_w;
    w1_q   <= w_in;
    f1_q   <= f_in;
    flt1_q <= e_ss.ovf | e_w2.ovf | e_cs.ovf | e_a.ovf | e_cd.ovf | e_lf.ovf
            | e_dw.ovf | e_mlc.ovf;
  end

  assign e_mss    = cpd_pkg::mulq(pm, ss1_q);
  assign e_ac     = cpd_pkg::mulq(a1_q, c1_q);
  assign e_mllw2  = cpd_pkg::mulq(mll_q, w21_q);
  assign e_cdw    = cpd_pkg::mulq(cd1_q, w1_q);
  assign e_dwmm   = cpd_pkg::mulq(dw1_q, mm_q);
  assign e_amm    = cpd_pkg::mulq(a1_q, mm_q);
  assign e_mlcf   = cpd_pkg::mulq(mlc1_q, f1_q);
  assign e_mmllw2 = cpd_pkg::mulq(mmll_q, w21_q);

  always_ff @(posedge clk_i) begin
    mss2_q    <= e_mss.val;
    ac2_q     <= e_ac.val;
    mllw22_q  <= e_mllw2.val;
    cdw2_q    <= e_cdw.val;
    dwmm2_q   <= e_dwmm.val;
    amm2_q    <= e_amm.val;
    mlcf2_q   <= e_mlcf.val;
    mmllw22_q <= e_mmllw2.val;
    s2_q      <= s1_q;
    cs2_q     <= cs1_q;
    lf2_q     <= lf1_q;
    flt2_q    <= flt1_q | e_mss.ovf | e_ac.ovf | e_mllw2.ovf | e_cdw.ovf | e_dwmm.ovf
               | e_amm.ovf | e_mlcf.ovf | e_mmllw2.ovf;
  end

  assign e_dd = cpd_pkg::sat33(33'(cm) + 33'(mss2_q));
  assign e_t2 = cpd_pkg::mulq(mllw22_q, s2_q);
  assign e_t4 = cpd_pkg::mulq(mmllw22_q, cs2_q);

  always_ff @(posedge clk_i) begin
    dd3_q   <= e_dd.val;
    t23_q   <= e_t2.val;
    t43_q   <= e_t4.val;
    ac3_q   <= ac2_q;
    cdw3_q  <= cdw2_q;
    lf3_q   <= lf2_q;
    dwmm3_q <= dwmm2_q;
    amm3_q  <= amm2_q;
    mlcf3_q <= mlcf2_q;
    flt3_q  <= flt2_q | e_dd.ovf | e_t2.ovf | e_t4.ovf;
  end

  assign n1_sum = 35'(t23_q) + 35'(cdw3_q) + 35'(lf3_q) - 35'(ac3_q);
  assign n2_sum = 35'(dwmm3_q) - 35'(amm3_q) + 35'(mlcf3_q) + 35'(t43_q);
  assign e_den1 = cpd_pkg::mulq(dd3_q, pl);
  assign e_den2 = cpd_pkg::mulq(dd3_q, mll_q);

  always_ff @(posedge clk_i) begin
    num1_q <= n1_sum;
    num2_q <= -n2_sum;
    den1_q <= e_den1.val;
    den2_q <= e_den2.val;
    flt4_q <= flt3_q | e_den1.ovf | e_den2.ovf | cfg_flt_q;
  end

  cpd_div u_div_cart (
    .clk_i (clk_i),
    .num_i (num1_q),
    .den_i (den1_q),
    .quo_o (q1),
    .flt_o (qf1)
  );

  cpd_div u_div_pole (
    .clk_i (clk_i),
    .num_i (num2_q),
    .den_i (den2_q),
    .quo_o (q2),
    .flt_o (qf2)
  );

  assign done_o          = vld_q[TL-1];
  assign position_rate_o = vel_dly[TL-1];
  assign angle_rate_o    = rate_dly[TL-1];
  assign cart_accel_o    = q1;
  assign angular_accel_o = q2;
  assign math_error_o    = flt_dly[DL-1] | qf1 | qf2;

`ifndef NO_ASSERTIONS
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, cpd_pkg::TOT_LAT))
    else $error("result strobe without a matching request");

  a_velocity_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> position_rate_o == $past(cart_velocity_i, cpd_pkg::TOT_LAT))
    else $error("position rate does not match the requested cart velocity");

  a_rate_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> angle_rate_o == $past(angular_rate_i, cpd_pkg::TOT_LAT))
    else $error("angle rate does not match the requested angular rate");
`endif

endmodule
